### rtl/vertex_normal_accumulator_assert.svh
// assertion macros for the vertex normal accumulator
// used by files that carry concurrent checks; no other dependencies
`ifndef VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NVA_AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define NVA_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/nvacc_pkg.sv
// shared constants and types for the vertex normal accumulator
// no dependencies
`timescale 1ns / 1ps

package nvacc_pkg;

    localparam int MAX_V    = 1024;
    localparam int VIDX_W   = 10;
    localparam int VCNT_W   = 11;
    localparam int POS_W    = 16;
    localparam int NRM_W    = 16;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 8;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // shared divider: quotient is known to stay below 2^QUO_W
    localparam int QUO_W    = 16;
    localparam int DNUM_W   = 40;
    localparam int DDEN_W   = 26;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FACE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_DEGEN  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOFACE = 3'd3;
    localparam logic [STAT_W-1:0] ST_SAT    = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### rtl/nvacc_item_if.sv
// input item channel of the vertex normal accumulator
// depends on nvacc_pkg
`timescale 1ns / 1ps

interface nvacc_item_if;
    logic                             valid;
    logic                             ready;
    logic [nvacc_pkg::KIND_W-1:0]     kind;
    logic [nvacc_pkg::VIDX_W-1:0]     vertex_index;
    logic [nvacc_pkg::VIDX_W-1:0]     second_index;
    logic [nvacc_pkg::VIDX_W-1:0]     third_index;
    logic signed [nvacc_pkg::POS_W-1:0] pos_x;
    logic signed [nvacc_pkg::POS_W-1:0] pos_y;
    logic signed [nvacc_pkg::POS_W-1:0] pos_z;

    modport source (output valid, kind, vertex_index, second_index, third_index,
                    pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, kind, vertex_index, second_index, third_index,
                  pos_x, pos_y, pos_z, output ready);
endinterface

### rtl/nvacc_result_if.sv
// result channel of the vertex normal accumulator
// depends on nvacc_pkg
`timescale 1ns / 1ps

interface nvacc_result_if;
    logic                               valid;
    logic                               ready;
    logic [nvacc_pkg::STAT_W-1:0]       status;
    logic signed [nvacc_pkg::NRM_W-1:0] normal_x;
    logic signed [nvacc_pkg::NRM_W-1:0] normal_y;
    logic signed [nvacc_pkg::NRM_W-1:0] normal_z;

    modport source (output valid, status, normal_x, normal_y, normal_z, input ready);
    modport sink (input valid, status, normal_x, normal_y, normal_z, output ready);
endinterface

### rtl/nvacc_div.sv
// restoring divider, one quotient bit per cycle
// depends on nvacc_pkg; caller guarantees num >> QUO_W is below den
`timescale 1ns / 1ps

module nvacc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nvacc_pkg::DNUM_W-1:0]  i_num,
    input  logic [nvacc_pkg::DDEN_W-1:0]  i_den,
    output nvacc_pkg::t_div_stat          o_stat,
    output logic [nvacc_pkg::QUO_W-1:0]   o_quo
);

    localparam int QW = nvacc_pkg::QUO_W;
    localparam int DW = nvacc_pkg::DDEN_W;
    localparam int NW = nvacc_pkg::DNUM_W;

    logic [DW-1:0]          r_rem;
    logic [DW-1:0]          r_den;
    logic [QW-1:0]          r_nq;
    logic [$clog2(QW)-1:0]  r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [DW:0]            n_trial;
    logic                   n_fit;

    assign n_trial = {r_rem, r_nq[QW-1]};
    assign n_fit   = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= DW'(i_num[NW-1:QW]);
                r_nq   <= i_num[QW-1:0];
                r_den  <= i_den;
            end else if (r_busy) begin
                // quotient bits shift in where numerator bits shift out
                r_rem <= n_fit ? DW'(n_trial - {1'b0, r_den}) : n_trial[DW-1:0];
                r_nq  <= {r_nq[QW-2:0], n_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(QW))'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_nq;

endmodule

### rtl/vertex_normal_accumulator.sv
// vertex normal accumulator: one item in flight, taken only while idle
// a read divides each sum by the face count, unless the vertex has no faces; a face runs
// a cross product, a normalizing shift, a 26-step square root, three divides and three
// corner updates (a degenerate face goes straight to the corner updates); output stalls
// add their cycles. the result is loaded into the output register as the block goes idle.
// reset (synchronous, active low) runs a clearing pass over all 1024 entries of the sum and
// count memory, during which no item is taken; vertex_count returns to 1024
`timescale 1ns / 1ps

`include "vertex_normal_accumulator_assert.svh"

module vertex_normal_accumulator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    nvacc_item_if.sink                      i_item,
    nvacc_result_if.source                  o_result,
    input  logic                            i_cfg_we,
    input  logic [nvacc_pkg::VCNT_W-1:0]    i_cfg_data
);

    localparam int VW  = nvacc_pkg::VIDX_W;
    localparam int PW  = nvacc_pkg::POS_W;
    localparam int SW  = nvacc_pkg::SUM_W;
    localparam int CW  = nvacc_pkg::CNT_W;
    localparam int NW  = nvacc_pkg::NRM_W;
    localparam int AW  = 3 * SW + CW;
    localparam int QW  = nvacc_pkg::QUO_W;
    localparam int DNW = nvacc_pkg::DNUM_W;
    localparam int DDW = nvacc_pkg::DDEN_W;
    localparam int DFW = PW + 1;
    localparam int PRW = 2 * DFW;
    localparam int CRW = PRW + 1;
    localparam int MW  = PRW;
    localparam int QSW = 51;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_RB, S_RC, S_DIFF, S_MUL, S_MAG, S_NORM, S_SQ, S_SQRT, S_NLEN,
        S_NDIV, S_NWAIT, S_ARD, S_AWR, S_AVG, S_ADIV, S_AWAIT, S_OUT
    } t_state;

    t_state r_state;

    // memories
    logic [3*PW-1:0] r_pos_mem [nvacc_pkg::MAX_V];
    logic [3*PW-1:0] r_pos_rd;
    logic [AW-1:0]   r_acc_mem [nvacc_pkg::MAX_V];
    logic [AW-1:0]   r_acc_rd;

    logic            pos_we;
    logic [VW-1:0]   pos_raddr;
    logic            acc_we;
    logic [VW-1:0]   acc_addr;
    logic [AW-1:0]   acc_wdata;

    // control and datapath registers
    logic [nvacc_pkg::VCNT_W-1:0] r_vcount;
    logic [VW-1:0]                r_clr;
    logic [nvacc_pkg::KIND_W-1:0] r_kind;
    logic [VW-1:0]                r_corner [3];
    logic [1:0]                   r_j;
    logic [2:0]                   r_step;
    logic [3*PW-1:0]              r_pa;
    logic [3*PW-1:0]              r_pb;
    logic signed [DFW-1:0]        r_d1 [3];
    logic signed [DFW-1:0]        r_d2 [3];
    logic signed [PRW-1:0]        r_prod;
    logic signed [CRW-1:0]        r_cr [3];
    logic [MW-1:0]                r_m [3];
    logic                         r_neg [3];
    logic [QSW-1:0]               r_sq;
    logic [QSW-1:0]               r_res;
    logic [QSW-1:0]               r_bit;
    logic [24:0]                  r_len;
    logic signed [NW-1:0]         r_n [3];
    logic signed [SW-1:0]         r_sum [3];
    logic [CW-1:0]                r_cnt;
    logic                         r_sat;
    logic                         r_degen;
    logic [nvacc_pkg::STAT_W-1:0] r_status;

    logic                         r_ovalid;
    logic [nvacc_pkg::STAT_W-1:0] r_o_status;
    logic signed [NW-1:0]         r_o_n [3];

    // combinational helpers
    logic                         take;
    logic                         ok_a, ok_b, ok_c;
    logic signed [DFW-1:0]        n_opa, n_opb;
    logic signed [PRW-1:0]        n_mul;
    logic [QSW-1:0]               n_trial;
    logic                         div_start;
    logic [DNW-1:0]               div_num;
    logic [DDW-1:0]               div_den;
    nvacc_pkg::t_div_stat         div_stat;
    logic [QW-1:0]                div_quo;
    logic [SW-1:0]                n_mag;
    logic [CW-1:0]                acc_wcnt;
    logic [SW-1:0]                n_amag;

    function automatic logic signed [PW-1:0] pos_comp(input logic [3*PW-1:0] v,
                                                      input int unsigned k);
        logic signed [PW-1:0] c;
        case (k)
            0:       c = v[3*PW-1:2*PW];
            1:       c = v[2*PW-1:PW];
            default: c = v[PW-1:0];
        endcase
        return c;
    endfunction

    function automatic logic signed [SW-1:0] acc_sum(input logic [AW-1:0] v,
                                                     input int unsigned k);
        logic signed [SW-1:0] s;
        case (k)
            0:       s = v[AW-1:AW-SW];
            1:       s = v[AW-SW-1:AW-2*SW];
            default: s = v[AW-2*SW-1:CW];
        endcase
        return s;
    endfunction

    assign take = i_item.valid && i_item.ready;
    assign ok_a = {1'b0, i_item.vertex_index} < r_vcount;
    assign ok_b = {1'b0, i_item.second_index} < r_vcount;
    assign ok_c = {1'b0, i_item.third_index} < r_vcount;

    assign i_item.ready = (r_state == S_IDLE);

    assign pos_we = take && (i_item.kind == nvacc_pkg::KIND_WRITE) && ok_a;

    always_comb begin
        case (r_state)
            S_RB:    pos_raddr = r_corner[1];
            S_RC:    pos_raddr = r_corner[2];
            default: pos_raddr = i_item.vertex_index;
        endcase
    end

    // accumulator port: clearing sweep, corner updates, read items
    assign acc_wcnt = r_acc_rd[CW-1:0] + 1'b1;
    always_comb begin
        acc_we    = 1'b0;
        acc_addr  = r_corner[r_j];
        acc_wdata = '0;
        case (r_state)
            S_CLR: begin
                acc_we   = 1'b1;
                acc_addr = r_clr;
            end
            S_IDLE: begin
                acc_addr = i_item.vertex_index;
            end
            S_AWR: begin
                acc_we    = r_acc_rd[CW-1:0] != nvacc_pkg::CNT_MAX;
                acc_wdata = {SW'(acc_sum(r_acc_rd, 0) + SW'(r_n[0])),
                             SW'(acc_sum(r_acc_rd, 1) + SW'(r_n[1])),
                             SW'(acc_sum(r_acc_rd, 2) + SW'(r_n[2])),
                             acc_wcnt};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we)
            r_pos_mem[i_item.vertex_index] <= {i_item.pos_x, i_item.pos_y, i_item.pos_z};
        r_pos_rd <= r_pos_mem[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we)
            r_acc_mem[acc_addr] <= acc_wdata;
        r_acc_rd <= r_acc_mem[acc_addr];
    end

    // cross product terms, one product per cycle
    always_comb begin
        case (r_step)
            3'd0:    begin n_opa = r_d1[1]; n_opb = r_d2[2]; end
            3'd1:    begin n_opa = r_d1[2]; n_opb = r_d2[1]; end
            3'd2:    begin n_opa = r_d1[2]; n_opb = r_d2[0]; end
            3'd3:    begin n_opa = r_d1[0]; n_opb = r_d2[2]; end
            3'd4:    begin n_opa = r_d1[0]; n_opb = r_d2[1]; end
            default: begin n_opa = r_d1[1]; n_opb = r_d2[0]; end
        endcase
    end
    assign n_mul   = n_opa * n_opb;
    assign n_trial = r_res + r_bit;

    // shared divider operands
    assign n_mag  = r_neg[r_step[1:0]] ? SW'(-r_sum[r_step[1:0]]) : SW'(r_sum[r_step[1:0]]);
    assign n_amag = n_mag;
    always_comb begin
        if (r_state == S_ADIV) begin
            div_num = DNW'({n_amag, 1'b0}) + DNW'(r_cnt);
            div_den = DDW'({r_cnt, 1'b0});
        end else begin
            div_num = DNW'({r_m[r_step[1:0]][23:0], 15'd0}) + DNW'(r_len);
            div_den = DDW'({r_len, 1'b0});
        end
    end
    assign div_start = (r_state == S_ADIV) || (r_state == S_NDIV);

    nvacc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_vcount <= nvacc_pkg::VCNT_W'(nvacc_pkg::MAX_V);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we)
                r_vcount <= i_cfg_data;
            if (r_ovalid && o_result.ready)
                r_ovalid <= 1'b0;

            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == VW'(nvacc_pkg::MAX_V - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (take) begin
                        r_kind     <= i_item.kind;
                        r_corner[0] <= i_item.vertex_index;
                        r_corner[1] <= i_item.second_index;
                        r_corner[2] <= i_item.third_index;
                        r_n[0]     <= '0;
                        r_n[1]     <= '0;
                        r_n[2]     <= '0;
                        r_sat      <= 1'b0;
                        r_degen    <= 1'b0;
                        r_j        <= '0;
                        r_step     <= '0;
                        r_status   <= nvacc_pkg::ST_OK;
                        r_state    <= S_OUT;
                        case (i_item.kind)
                            nvacc_pkg::KIND_WRITE: begin
                                if (!ok_a) r_status <= nvacc_pkg::ST_RANGE;
                            end
                            nvacc_pkg::KIND_FACE: begin
                                if (ok_a && ok_b && ok_c) r_state <= S_RB;
                                else r_status <= nvacc_pkg::ST_RANGE;
                            end
                            nvacc_pkg::KIND_READ: begin
                                if (ok_a) r_state <= S_AVG;
                                else r_status <= nvacc_pkg::ST_RANGE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RB: begin
                    r_pa    <= r_pos_rd;
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_pb    <= r_pos_rd;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_d1[i] <= DFW'(pos_comp(r_pa, i)) - DFW'(pos_comp(r_pb, i));
                        r_d2[i] <= DFW'(pos_comp(r_pos_rd, i)) - DFW'(pos_comp(r_pb, i));
                    end
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (!r_step[0])
                        r_prod <= n_mul;
                    else
                        r_cr[r_step[2:1]] <= CRW'(r_prod) - CRW'(n_mul);
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd5)
                        r_state <= S_MAG;
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= r_cr[i] < 0;
                        r_m[i]   <= r_cr[i] < 0 ? MW'(-r_cr[i]) : MW'(r_cr[i]);
                    end
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // one bit of shift a cycle until the largest lies in [2^23, 2^24)
                    if (r_m[0] == '0 && r_m[1] == '0 && r_m[2] == '0) begin
                        r_degen <= 1'b1;
                        r_j     <= '0;
                        r_state <= S_ARD;
                    end else if (r_m[0][MW-1:24] != '0 || r_m[1][MW-1:24] != '0 ||
                                 r_m[2][MW-1:24] != '0) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (!r_m[0][23] && !r_m[1][23] && !r_m[2][23]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_sq    <= '0;
                        r_step  <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sq   <= r_sq + QSW'(r_m[r_step[1:0]][23:0] * r_m[r_step[1:0]][23:0]);
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd2) begin
                        r_res   <= '0;
                        r_bit   <= QSW'(1) << (QSW - 1);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sq >= n_trial) begin
                        r_sq  <= r_sq - n_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_step  <= '0;
                        r_state <= S_NLEN;
                    end
                end
                S_NLEN: begin
                    r_len   <= r_res[24:0];
                    r_state <= S_NDIV;
                end
                S_NDIV: begin
                    r_state <= S_NWAIT;
                end
                S_NWAIT: begin
                    if (div_stat.done) begin
                        r_n[r_step[1:0]] <= r_neg[r_step[1:0]] ? -NW'(div_quo) : NW'(div_quo);
                        r_step <= r_step + 1'b1;
                        if (r_step == 3'd2) begin
                            r_j     <= '0;
                            r_state <= S_ARD;
                        end else begin
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_ARD: begin
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    if (r_acc_rd[CW-1:0] == nvacc_pkg::CNT_MAX)
                        r_sat <= 1'b1;
                    if (r_j == 2'd2) begin
                        if (r_sat || r_acc_rd[CW-1:0] == nvacc_pkg::CNT_MAX)
                            r_status <= nvacc_pkg::ST_SAT;
                        else if (r_degen)
                            r_status <= nvacc_pkg::ST_DEGEN;
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                S_AVG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_sum[i] <= acc_sum(r_acc_rd, i);
                        r_neg[i] <= acc_sum(r_acc_rd, i) < 0;
                    end
                    r_cnt  <= r_acc_rd[CW-1:0];
                    r_step <= '0;
                    if (r_acc_rd[CW-1:0] == '0) begin
                        r_status <= nvacc_pkg::ST_NOFACE;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_ADIV;
                    end
                end
                S_ADIV: begin
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    if (div_stat.done) begin
                        r_n[r_step[1:0]] <= r_neg[r_step[1:0]] ? -NW'(div_quo) : NW'(div_quo);
                        r_step <= r_step + 1'b1;
                        r_state <= (r_step == 3'd2) ? S_OUT : S_ADIV;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_result.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_status;
                        // only read items carry a normal, faces answer zeros
                        for (int i = 0; i < 3; i++)
                            r_o_n[i] <= (r_kind == nvacc_pkg::KIND_READ) ? r_n[i] : '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid    = r_ovalid;
    assign o_result.status   = r_o_status;
    assign o_result.normal_x = r_o_n[0];
    assign o_result.normal_y = r_o_n[1];
    assign o_result.normal_z = r_o_n[2];

    `NVA_AST_IMPL(a_no_take_in_clear, i_clk, i_rst_n, r_state == S_CLR, !i_item.ready)
    `NVA_AST_IMPL(a_div_start_idle, i_clk, i_rst_n, div_start, !div_stat.busy)
    `NVA_AST_IMPL(a_len_normalized, i_clk, i_rst_n, r_state == S_NDIV, r_len[24:23] != 2'b00)
    `NVA_AST_IMPL(a_corner_cnt_grows, i_clk, i_rst_n, acc_we && r_state == S_AWR, acc_wcnt != '0)
    `NVA_AST_NEXT(a_out_loads, i_clk, i_rst_n, r_state == S_OUT && !r_ovalid, o_result.valid)

endmodule

### tb/vertex_normal_accumulator_tb.sv
// self-checking bench for vertex_normal_accumulator: directed tests, then random meshes
// depends on nvacc_pkg, nvacc_item_if, nvacc_result_if and vertex_normal_accumulator
`timescale 1ns / 1ps

module vertex_normal_accumulator_tb;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_V        = nvacc_pkg::MAX_V;

    // the one kind code with no meaning
    localparam logic [nvacc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic [nvacc_pkg::KIND_W-1:0]       kind;
        logic [nvacc_pkg::VIDX_W-1:0]       ia;
        logic [nvacc_pkg::VIDX_W-1:0]       ib;
        logic [nvacc_pkg::VIDX_W-1:0]       ic;
        logic signed [nvacc_pkg::POS_W-1:0] px;
        logic signed [nvacc_pkg::POS_W-1:0] py;
        logic signed [nvacc_pkg::POS_W-1:0] pz;
    } t_mesh_op;

    typedef struct {
        logic [nvacc_pkg::STAT_W-1:0]       status;
        logic signed [nvacc_pkg::NRM_W-1:0] nx;
        logic signed [nvacc_pkg::NRM_W-1:0] ny;
        logic signed [nvacc_pkg::NRM_W-1:0] nz;
    } t_normal_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [nvacc_pkg::VCNT_W-1:0] i_cfg_data;

    nvacc_item_if   item_ch();
    nvacc_result_if res_ch();

    vertex_normal_accumulator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // mirror of the block state
    int             pos_mem [MAX_V][3];
    int             sum_mem [MAX_V][3];
    int unsigned    cnt_mem [MAX_V];
    bit             written [MAX_V];
    int unsigned    vcount;
    int unsigned    written_list[$];

    t_normal_beat   pending_normals[$];
    int             fail_count;
    int             cycle_count;
    bit             no_idle;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 65) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    function automatic bit idx_ok(logic [nvacc_pkg::VIDX_W-1:0] idx);
        return idx < vcount && idx < MAX_V;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit normal of one face in Q1.14; false when the cross product is zero
    function automatic bit face_normal(longint cr[3], output int n[3]);
        longint unsigned m[3], mx, sq, len, q;
        mx = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (m[i] > mx) mx = m[i];
            n[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 24)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 23)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sq += m[i] * m[i];
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = (2 * m[i] * 16384 + len) / (2 * len);
            n[i] = cr[i] < 0 ? -int'(q) : int'(q);
        end
        return 1;
    endfunction

    function automatic int avg_round(int s, int unsigned c);
        int unsigned mag, q;
        mag = s < 0 ? -s : s;
        q = (2 * mag + c) / (2 * c);
        return s < 0 ? -int'(q) : int'(q);
    endfunction

    function automatic t_normal_beat apply_mesh_op(t_mesh_op op);
        t_normal_beat r;
        longint d1[3], d2[3], cr[3];
        int n[3];
        int unsigned corner[3];
        bit sat, nonzero;
        r = '{nvacc_pkg::ST_OK, 0, 0, 0};
        case (op.kind)
            nvacc_pkg::KIND_WRITE: begin
                if (!idx_ok(op.ia)) begin
                    r.status = nvacc_pkg::ST_RANGE;
                end else begin
                    pos_mem[op.ia] = '{int'(op.px), int'(op.py), int'(op.pz)};
                    if (!written[op.ia]) written_list.push_back(op.ia);
                    written[op.ia] = 1;
                end
            end
            nvacc_pkg::KIND_FACE: begin
                if (!idx_ok(op.ia) || !idx_ok(op.ib) || !idx_ok(op.ic)) begin
                    r.status = nvacc_pkg::ST_RANGE;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        d1[i] = longint'(pos_mem[op.ia][i]) - pos_mem[op.ib][i];
                        d2[i] = longint'(pos_mem[op.ic][i]) - pos_mem[op.ib][i];
                    end
                    cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
                    cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
                    cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
                    nonzero = face_normal(cr, n);
                    corner = '{op.ia, op.ib, op.ic};
                    sat = 0;
                    // repeated corners are updated once per mention
                    for (int i = 0; i < 3; i++) begin
                        if (cnt_mem[corner[i]] >= 255) begin
                            sat = 1;
                        end else begin
                            for (int k = 0; k < 3; k++) sum_mem[corner[i]][k] += n[k];
                            cnt_mem[corner[i]]++;
                        end
                    end
                    if (sat) r.status = nvacc_pkg::ST_SAT;
                    else if (!nonzero) r.status = nvacc_pkg::ST_DEGEN;
                end
            end
            nvacc_pkg::KIND_READ: begin
                if (!idx_ok(op.ia)) begin
                    r.status = nvacc_pkg::ST_RANGE;
                end else if (cnt_mem[op.ia] == 0) begin
                    r.status = nvacc_pkg::ST_NOFACE;
                end else begin
                    r.nx = avg_round(sum_mem[op.ia][0], cnt_mem[op.ia]);
                    r.ny = avg_round(sum_mem[op.ia][1], cnt_mem[op.ia]);
                    r.nz = avg_round(sum_mem[op.ia][2], cnt_mem[op.ia]);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // one beat on the item channel; valid stays high when the next beat follows at once
    task automatic send_op(t_mesh_op op);
        @(negedge i_clk);
        item_ch.valid        = 1'b1;
        item_ch.kind         = op.kind;
        item_ch.vertex_index = op.ia;
        item_ch.second_index = op.ib;
        item_ch.third_index  = op.ic;
        item_ch.pos_x        = op.px;
        item_ch.pos_y        = op.py;
        item_ch.pos_z        = op.pz;
        do @(posedge i_clk); while (!item_ch.ready);
        pending_normals.push_back(apply_mesh_op(op));
        repeat (gap_len()) begin
            @(negedge i_clk);
            item_ch.valid = 1'b0;
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(int unsigned value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value[nvacc_pkg::VCNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        vcount     = value & 11'h7FF;
    endtask

    function automatic t_mesh_op op_write(int idx, int x, int y, int z);
        return '{nvacc_pkg::KIND_WRITE, idx[nvacc_pkg::VIDX_W-1:0], 10'($urandom),
                 10'($urandom), 16'(x), 16'(y), 16'(z)};
    endfunction

    function automatic t_mesh_op op_face(int a, int b, int c);
        return '{nvacc_pkg::KIND_FACE, a[nvacc_pkg::VIDX_W-1:0], b[nvacc_pkg::VIDX_W-1:0],
                 c[nvacc_pkg::VIDX_W-1:0], 16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    function automatic t_mesh_op op_read(int idx);
        return '{nvacc_pkg::KIND_READ, idx[nvacc_pkg::VIDX_W-1:0], 10'($urandom),
                 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // result side: random backpressure, checks each beat against the oldest expectation
    always @(negedge i_clk) begin
        res_ch.ready <= (gap_len() == 0);
    end

    always @(posedge i_clk) begin
        t_normal_beat want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_normals.size() == 0) begin
                report_mismatch("status of unexpected beat", res_ch.status, -1);
            end else begin
                want = pending_normals.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", res_ch.status, want.status);
                if (res_ch.normal_x !== want.nx)
                    report_mismatch("normal_x", res_ch.normal_x, want.nx);
                if (res_ch.normal_y !== want.ny)
                    report_mismatch("normal_y", res_ch.normal_y, want.ny);
                if (res_ch.normal_z !== want.nz)
                    report_mismatch("normal_z", res_ch.normal_z, want.nz);
            end
        end
    end

    task automatic test_basic_triangle();
        send_op(op_read(0));                       // no faces yet
        send_op(op_write(0, 0, 0, 0));
        send_op(op_write(1, 256, 0, 0));
        send_op(op_write(2, 0, 256, 0));
        send_op(op_face(1, 0, 2));
        send_op(op_face(2, 0, 1));                 // opposite winding cancels
        send_op(op_read(0));
        send_op(op_read(1));
        send_op(op_face(1, 0, 2));
        send_op(op_read(2));
        send_op('{KIND_SPARE, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    endtask

    task automatic test_extremes();
        send_op(op_write(1023, 32767, -32768, 32767));
        send_op(op_write(1022, -32768, 32767, -32768));
        send_op(op_write(1021, 32767, 32767, -32768));
        send_op(op_face(1023, 1022, 1021));
        send_op(op_face(1023, 1023, 1022));        // repeated corner, degenerate
        send_op(op_face(0, 1, 0));                 // degenerate, repeated corner
        send_op(op_write(3, 512, 0, 0));
        send_op(op_face(0, 1, 3));                 // collinear
        send_op(op_read(1023));
        send_op(op_read(1021));
        send_op(op_read(3));
    endtask

    task automatic test_index_range();
        write_vertex_count(3);
        send_op(op_write(3, 1, 2, 3));
        send_op(op_face(0, 1, 5));
        send_op(op_read(3));
        send_op(op_read(2));
        write_vertex_count(0);
        send_op(op_write(0, 7, 7, 7));
        send_op(op_read(0));
        send_op(op_face(0, 1, 2));
        write_vertex_count(2047);
        send_op(op_read(1023));
        write_vertex_count(1024);
    endtask

    task automatic test_count_saturation();
        send_op(op_write(5, 100, 200, 300));
        send_op(op_write(6, -100, 50, 25));
        send_op(op_write(7, 300, -20, 90));
        no_idle = 1;
        for (int i = 0; i < 86; i++) send_op(op_face(5, 5, 5));
        no_idle = 0;
        send_op(op_face(5, 6, 7));                 // vertex 5 dropped, others added
        send_op(op_read(5));
        send_op(op_read(6));
    endtask

    function automatic int pick_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    function automatic int pick_corner();
        int r;
        r = $urandom_range(99);
        if (r < 3 && vcount < MAX_V) return $urandom_range(MAX_V - 1, vcount);
        return pick_written();
    endfunction

    task automatic test_random_mesh(int n_ops, int pool);
        int r;
        for (int i = 0; i < n_ops; i++) begin
            if (i % 50 == 0) no_idle = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < 22 || written_list.size() == 0) begin
                if ($urandom_range(9) == 0)
                    send_op(op_write($urandom_range(MAX_V - 1), $urandom, $urandom,
                                     $urandom));
                else
                    send_op(op_write($urandom_range(pool - 1), $urandom, $urandom,
                                     $urandom));
            end else if (r < 70) begin
                send_op(op_face(pick_corner(), pick_corner(), pick_corner()));
            end else if (r < 96) begin
                if ($urandom_range(4) == 0) send_op(op_read($urandom_range(MAX_V - 1)));
                else send_op(op_read($urandom_range(pool - 1)));
            end else begin
                send_op('{KIND_SPARE, 10'($urandom), 10'($urandom), 10'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom)});
            end
        end
        no_idle = 0;
    endtask

    initial begin
        fail_count   = 0;
        cycle_count  = 0;
        no_idle      = 0;
        vcount       = 1024;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = nvacc_pkg::KIND_WRITE;
        item_ch.vertex_index = '0;
        item_ch.second_index = '0;
        item_ch.third_index  = '0;
        item_ch.pos_x        = '0;
        item_ch.pos_y        = '0;
        item_ch.pos_z        = '0;
        res_ch.ready         = 1'b0;
        for (int v = 0; v < MAX_V; v++) begin
            pos_mem[v] = '{0, 0, 0};
            sum_mem[v] = '{0, 0, 0};
            cnt_mem[v] = 0;
            written[v] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_triangle();
        test_extremes();
        test_index_range();
        test_count_saturation();
        test_random_mesh(200, 24);
        write_vertex_count($urandom_range(40, 8));
        test_random_mesh(120, 48);
        write_vertex_count(2047);
        test_random_mesh(160, 32);

        wait_idle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/nvacc_pkg.sv
rtl/nvacc_item_if.sv
rtl/nvacc_result_if.sv
rtl/nvacc_div.sv
rtl/vertex_normal_accumulator.sv
tb/vertex_normal_accumulator_tb.sv
